### design/ppr_pkg.sv
// Shared widths, reset values, register indexes and state encoding for the pulse rate detector.
package ppr_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int TIME_W     = 32;
    localparam int GAP_W      = 16;
    localparam int LEVEL_W    = 8;
    localparam int RATE_W     = 8;
    localparam int IVL_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DEFAULT_INTERVAL_SLOTS = 4;

    localparam logic [IVL_W-1:0]    RATE_NUMERATOR    = IVL_W'(60000);
    localparam logic [SAMPLE_W-1:0] PREV_SAMPLE_RESET = SAMPLE_W'(128);
    localparam logic [GAP_W-1:0]    MIN_GAP_RESET     = GAP_W'(333);
    localparam logic [LEVEL_W-1:0]  PEAK_MARGIN_RESET = LEVEL_W'(2);
    localparam logic [RATE_W-1:0]   MIN_RATE_RESET    = RATE_W'(40);
    localparam logic [RATE_W-1:0]   MAX_RATE_RESET    = RATE_W'(180);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_GAP     = 2'd0,
        CFG_PEAK_MARGIN = 2'd1,
        CFG_MIN_RATE    = 2'd2,
        CFG_MAX_RATE    = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_RATE,
        ST_RATE_WAIT,
        ST_RESULT
    } ppr_state_t;

endpackage

### design/ppr_if.sv
// Valid/ready channels for sample items and result items.
interface ppr_sample_if
    import ppr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   time_ms;

    modport source (output valid, output sample, output time_ms, input ready);
    modport sink   (input valid, input sample, input time_ms, output ready);
endinterface

interface ppr_result_if
    import ppr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              beat;
    logic [RATE_W-1:0] rate_bpm;

    modport source (output valid, output beat, output rate_bpm, input ready);
    modport sink   (input valid, input beat, input rate_bpm, output ready);
endinterface

### design/ppr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module ppr_div
    import ppr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IVL_W-1:0] dvd_hi,
    input  logic [IVL_W-1:0] dvd_lo,
    input  logic [IVL_W-1:0] divisor,
    output logic [IVL_W-1:0] quotient,
    output logic             done
);

    localparam int STEP_W = $clog2(IVL_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(IVL_W - 1);

    logic [IVL_W-1:0]  rem_reg;
    logic [IVL_W-1:0]  rem_next;
    logic [IVL_W-1:0]  quo_reg;
    logic [IVL_W-1:0]  div_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [IVL_W:0]    rem_sh;
    logic [IVL_W:0]    rem_diff;
    logic              fits;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[IVL_W-1]};
        rem_diff = rem_sh - {1'b0, div_reg};
        fits     = (rem_sh >= {1'b0, div_reg});
        rem_next = fits ? rem_diff[IVL_W-1:0] : rem_sh[IVL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dvd_hi;
            quo_reg <= dvd_lo;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[IVL_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### design/pulse_peak_rate_detector.sv
// Pulse peak detector with interval ring and serial rate computation.
//
// sample_ch carries one item per sensor sample (sample, time_ms); result_ch
// returns exactly one item (beat, rate_bpm) for each. Registers are written
// through cfg_we / cfg_index / cfg_data; the user must do so only while no
// item is in flight, as the block does not enforce it.
//
// An item that completes no beat goes from idle straight to the result
// state. A beat walks the INTERVAL_SLOTS ring one slot per cycle, then runs
// two 16-step bit-serial divisions (mean interval, then 60000 / mean) on one
// shared divider. With every slot empty the divisions are skipped. One item
// is in work at a time, and sample_ch.ready is high only while the block is
// idle.
//
// Results sit in an output register, so the next item is taken while a
// finished result waits; a receiver stall past that blocks the block in its
// result state. Reset restores register defaults (gap 333 ms, margin 2,
// rate clamp 40..180), clears the ring and history and leaves rate 0.
module pulse_peak_rate_detector
    import ppr_pkg::*;
#(
    parameter int INTERVAL_SLOTS = DEFAULT_INTERVAL_SLOTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    ppr_sample_if.sink            sample_ch,
    ppr_result_if.source          result_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = (INTERVAL_SLOTS > 1) ? $clog2(INTERVAL_SLOTS) : 1;
    localparam int CNT_W  = $clog2(INTERVAL_SLOTS + 1);
    localparam int SUM_W  = IVL_W + CNT_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(INTERVAL_SLOTS - 1);

    logic [GAP_W-1:0]    min_gap_reg;
    logic [LEVEL_W-1:0]  margin_reg;
    logic [RATE_W-1:0]   min_rate_reg;
    logic [RATE_W-1:0]   max_rate_reg;

    logic [SAMPLE_W-1:0] prev_sample_reg;
    logic                was_rising_reg;
    logic [TIME_W-1:0]   last_time_reg;
    logic [LEVEL_W-1:0]  last_peak_reg;
    logic [IVL_W-1:0]    ring_reg [INTERVAL_SLOTS];
    logic [SLOT_W-1:0]   slot_reg;
    logic                beat_seen_reg;
    logic [RATE_W-1:0]   held_rate_reg;
    logic                beat_reg;

    logic [SLOT_W-1:0]   idx_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    count_reg;

    ppr_state_t          state_reg;
    ppr_state_t          state_next;

    logic                out_valid_reg;
    logic                out_beat_reg;
    logic [RATE_W-1:0]   out_rate_reg;

    logic                accept;
    logic                rising;
    logic [TIME_W-1:0]   elapsed;
    logic                beat_now;
    logic [IVL_W-1:0]    ring_word;

    logic                div_start;
    logic [IVL_W-1:0]    div_hi;
    logic [IVL_W-1:0]    div_lo;
    logic [IVL_W-1:0]    div_divisor;
    logic [IVL_W-1:0]    div_quo;
    logic                div_done;
    logic [RATE_W-1:0]   clamped;
    logic                out_load;

    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign accept          = sample_ch.valid && sample_ch.ready;

    always_comb
    begin
        rising   = sample_ch.sample > prev_sample_reg;
        elapsed  = sample_ch.time_ms - last_time_reg;
        beat_now = was_rising_reg && !rising
                   && (elapsed > {{(TIME_W-GAP_W){1'b0}}, min_gap_reg})
                   && ({1'b0, sample_ch.sample}
                       > ({1'b0, last_peak_reg} + {1'b0, margin_reg}));
        ring_word = ring_reg[idx_reg];
    end

    always_comb
    begin
        if (div_quo < {{(IVL_W-RATE_W){1'b0}}, min_rate_reg})
        begin
            clamped = min_rate_reg;
        end
        else if (div_quo > {{(IVL_W-RATE_W){1'b0}}, max_rate_reg})
        begin
            clamped = max_rate_reg;
        end
        else
        begin
            clamped = div_quo[RATE_W-1:0];
        end
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg  <= MIN_GAP_RESET;
            margin_reg   <= PEAK_MARGIN_RESET;
            min_rate_reg <= MIN_RATE_RESET;
            max_rate_reg <= MAX_RATE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_MIN_GAP:     min_gap_reg  <= cfg_data[GAP_W-1:0];
                CFG_PEAK_MARGIN: margin_reg   <= cfg_data[LEVEL_W-1:0];
                CFG_MIN_RATE:    min_rate_reg <= cfg_data[RATE_W-1:0];
                CFG_MAX_RATE:    max_rate_reg <= cfg_data[RATE_W-1:0];
            endcase
        end
    end

    // peak tracking and interval ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= PREV_SAMPLE_RESET;
            was_rising_reg  <= 1'b0;
            last_time_reg   <= '0;
            last_peak_reg   <= '0;
            slot_reg        <= '0;
            beat_seen_reg   <= 1'b0;
            beat_reg        <= 1'b0;
            for (int i = 0; i < INTERVAL_SLOTS; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            prev_sample_reg <= sample_ch.sample;
            was_rising_reg  <= rising;
            beat_reg        <= beat_now;
            if (beat_now)
            begin
                last_time_reg <= sample_ch.time_ms;
                last_peak_reg <= sample_ch.sample;
                beat_seen_reg <= 1'b1;
                if (beat_seen_reg)
                begin
                    ring_reg[slot_reg] <= elapsed[IVL_W-1:0];
                    slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                end
            end
        end
    end

    // walk the ring, then hold rate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            held_rate_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                idx_reg   <= '0;
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else if (state_reg == ST_SUM)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (ring_word != '0)
                begin
                    sum_reg   <= sum_reg + {{CNT_W{1'b0}}, ring_word};
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (state_reg == ST_MEAN && count_reg == '0)
            begin
                held_rate_reg <= '0;
            end
            else if (state_reg == ST_RATE_WAIT && div_done)
            begin
                held_rate_reg <= clamped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        div_start   = 1'b0;
        out_load    = 1'b0;
        div_hi      = {{(IVL_W-CNT_W){1'b0}}, sum_reg[SUM_W-1:IVL_W]};
        div_lo      = sum_reg[IVL_W-1:0];
        div_divisor = {{(IVL_W-CNT_W){1'b0}}, count_reg};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = beat_now ? ST_SUM : ST_RESULT;
                end
            end
            ST_SUM:
            begin
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_MEAN_WAIT;
                end
            end
            ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_RATE;
                end
            end
            ST_RATE:
            begin
                div_hi      = '0;
                div_lo      = RATE_NUMERATOR;
                div_divisor = div_quo;
                div_start   = 1'b1;
                state_next  = ST_RATE_WAIT;
            end
            ST_RATE_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    ppr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dvd_hi   (div_hi),
        .dvd_lo   (div_lo),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_beat_reg <= beat_reg;
            out_rate_reg <= held_rate_reg;
        end
    end

    assign result_ch.valid    = out_valid_reg;
    assign result_ch.beat     = out_beat_reg;
    assign result_ch.rate_bpm = out_rate_reg;

endmodule

### design/ppr_check.sv
// Port-level checks on the pulse rate detector, bound to the top level.
module ppr_check
    import ppr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              out_beat,
    input logic [RATE_W-1:0] out_rate
);

    logic              out_take;
    logic [RATE_W-1:0] last_rate_reg;
    logic [1:0]        beats_reg;

    assign out_take = out_valid && out_ready;

    // track last delivered rate and beats so far
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rate_reg <= '0;
            beats_reg     <= '0;
        end
        else if (out_take)
        begin
            last_rate_reg <= out_rate;
            if (out_beat && beats_reg != 2'd2)
            begin
                beats_reg <= beats_reg + 1'b1;
            end
        end
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_beat) && $stable(out_rate))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");

    a_rate_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !out_beat |-> out_rate == last_rate_reg)
        else $error("rate changed without a beat");

    a_rate_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && (beats_reg == 2'd0 || (beats_reg == 2'd1 && !out_beat))
        |-> out_rate == '0)
        else $error("rate reported before any interval");

endmodule

bind pulse_peak_rate_detector ppr_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_beat  (result_ch.beat),
    .out_rate  (result_ch.rate_bpm)
);
